>>> src/g7u8_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// g7u8_pkg
// Shared types, constants and lookup tables for the GSM 7-bit to UTF-8
// transcoder.
// ----------------------------------------------------------------------------
package g7u8_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned MAX_BYTES   = 4;
  localparam int unsigned BIDX_W      = $clog2(MAX_BYTES);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] ESC_CODE  = 8'h1B;
  localparam logic [CHAR_W-1:0] EURO_CODE = 8'h65;
  localparam logic [BYTE_W-1:0] NBSP_LEAD = 8'hC2;
  localparam logic [BYTE_W-1:0] NBSP_TAIL = 8'hA0;
  localparam logic [BYTE_W-1:0] EURO_B0   = 8'hE2;
  localparam logic [BYTE_W-1:0] EURO_B1   = 8'h82;
  localparam logic [BYTE_W-1:0] EURO_B2   = 8'hAC;
  localparam logic [BYTE_W-1:0] ERR_BYTE  = 8'h00;

  // One queued request: up to four bytes in output order (entry 0 first).
  typedef struct packed {
    logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
    logic [BIDX_W-1:0]                last_idx;
    logic                             msg_end;
    logic                             bad;
  } bundle_t;

  typedef struct packed {
    logic              hit;
    logic [BYTE_W-1:0] val;
  } ext_t;

  // Basic alphabet: two-byte entries carry the lead byte in [15:8].
  localparam logic [15:0] ROM_BASIC [128] = '{
    16'h0040, 16'hC2A3, 16'h0024, 16'hC2A5, 16'hC3A8, 16'hC3A9, 16'hC3B9, 16'hC3AC,
    16'hC3B2, 16'hC3A7, 16'h000A, 16'hC398, 16'hC3B8, 16'h000D, 16'hC385, 16'hC3A5,
    16'hCE94, 16'h005F, 16'hCEA6, 16'hCE93, 16'hCE9B, 16'hCEA9, 16'hCEA0, 16'hCEA8,
    16'hCEA3, 16'hCE98, 16'hCE9E, 16'hC2A0, 16'hC386, 16'hC3A6, 16'hC39F, 16'hC389,
    16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'hC2A4, 16'h0025, 16'h0026, 16'h0027,
    16'h0028, 16'h0029, 16'h002A, 16'h002B, 16'h002C, 16'h002D, 16'h002E, 16'h002F,
    16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
    16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E, 16'h003F,
    16'hC2A1, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
    16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
    16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
    16'h0058, 16'h0059, 16'h005A, 16'hC384, 16'hC396, 16'hC391, 16'hC39C, 16'hC2A7,
    16'hC2BF, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
    16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F,
    16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
    16'h0078, 16'h0079, 16'h007A, 16'hC3A4, 16'hC3B6, 16'hC3B1, 16'hC3BC, 16'hC3A0
  };

  // Single-byte extension set (the euro sign is handled separately).
  function automatic ext_t ext_single(input logic [CHAR_W-1:0] c);
    ext_t r;
    r.hit = 1'b1;
    unique case (c)
      8'h0A:   r.val = 8'h0C;
      8'h14:   r.val = 8'h5E;
      8'h28:   r.val = 8'h7B;
      8'h29:   r.val = 8'h7D;
      8'h2F:   r.val = 8'h5C;
      8'h3C:   r.val = 8'h5B;
      8'h3D:   r.val = 8'h7E;
      8'h3E:   r.val = 8'h5D;
      8'h40:   r.val = 8'h7C;
      default: begin
        r.hit = 1'b0;
        r.val = 8'h00;
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/gsm7_to_utf8_transcoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gsm7_to_utf8_transcoder_unit
// Converts unpacked GSM 7-bit characters (default alphabet plus extension
// set) into a UTF-8 byte stream.
// ----------------------------------------------------------------------------
// Path: with the serializer idle, an accepted character is written into the
//   queue on the accepting edge and then loaded into the serializer register,
//   from which its first byte is presented.
// Throughput: the serializer sends one byte per cycle while out_tready is
//   high; a character yields 1..4 bytes, and characters with no output
//   (pending escape, dropped tail) push nothing into the queue.
// Reset: rst_n synchronous active low; clears escape/drop state, queue and
//   output valid.
// ----------------------------------------------------------------------------
module gsm7_to_utf8_transcoder_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // character input
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] char_code
  input  wire logic       in_tlast,   // msg_last
  // UTF-8 byte output
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] utf8_byte
  output logic            out_tlast,  // msg_end
  output logic [1:0]      out_tuser   // [0] run_end, [1] bad_input
);

  g7u8_pkg::bundle_t push_data, head;
  logic              push, pop, q_empty, q_full;

  // Front: classifies each character; ready whenever the queue has room.
  g7u8_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (push),
    .q_data    (push_data)
  );

  // Queue decouples input stalls from output stalls.
  g7u8_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // Back: serializes each bundle one byte per cycle while out_tready is high.
  g7u8_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (head),
    .q_empty    (q_empty),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

>>> src/g7u8_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// g7u8_front
// Accepts characters, tracks escape and drop state, and turns each character
// into a bundle of up to four UTF-8 bytes for the queue.
// ----------------------------------------------------------------------------
module g7u8_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,   // [7:0] char_code
  input  wire logic              in_tlast,   // msg_last
  input  wire logic              q_full,
  output logic                   q_push,
  output g7u8_pkg::bundle_t      q_data
);

  logic                                   esc_r, esc_nxt;
  logic                                   drop_r, drop_nxt;
  logic [g7u8_pkg::CHAR_W-1:0]            c;
  logic                                   accept;
  g7u8_pkg::ext_t                         ext;
  logic [15:0]                            rom_val;
  logic                                   do_fresh, prefix, direct, bad;
  logic [1:0]                             fcnt;
  logic [g7u8_pkg::BYTE_W-1:0]            fb0, fb1;
  logic [g7u8_pkg::MAX_BYTES-1:0][g7u8_pkg::BYTE_W-1:0] dbytes, bytes;
  logic [2:0]                             dcnt, n;

  assign c         = in_tdata[g7u8_pkg::CHAR_W-1:0];
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign ext       = g7u8_pkg::ext_single(c);
  assign rom_val   = g7u8_pkg::ROM_BASIC[c[6:0]];

  always_comb begin
    esc_nxt  = esc_r;
    drop_nxt = drop_r;
    do_fresh = 1'b0;
    prefix   = 1'b0;
    direct   = 1'b0;
    bad      = 1'b0;
    dbytes   = '0;
    dcnt     = 3'd0;
    fcnt     = 2'd0;
    fb0      = '0;
    fb1      = '0;

    if (drop_r) begin
      if (in_tlast) drop_nxt = 1'b0;
    end else begin
      do_fresh = 1'b1;
      if (esc_r) begin
        esc_nxt = 1'b0;
        if (ext.hit) begin
          direct    = 1'b1;
          do_fresh  = 1'b0;
          dbytes[0] = ext.val;
          dcnt      = 3'd1;
        end else if (c == g7u8_pkg::EURO_CODE) begin
          direct    = 1'b1;
          do_fresh  = 1'b0;
          dbytes[0] = g7u8_pkg::EURO_B0;
          dbytes[1] = g7u8_pkg::EURO_B1;
          dbytes[2] = g7u8_pkg::EURO_B2;
          dcnt      = 3'd3;
        end else begin
          prefix = 1'b1;   // no-break space, then decode c as new
        end
      end

      if (do_fresh) begin
        if (c == g7u8_pkg::ESC_CODE) begin
          if (in_tlast) begin
            fb0  = g7u8_pkg::NBSP_LEAD;
            fb1  = g7u8_pkg::NBSP_TAIL;
            fcnt = 2'd2;
          end else begin
            esc_nxt = 1'b1;
          end
        end else if (c[7]) begin
          fb0      = g7u8_pkg::ERR_BYTE;
          fcnt     = 2'd1;
          bad      = 1'b1;
          drop_nxt = !in_tlast;
        end else if (rom_val[15:8] != 8'h00) begin
          fb0  = rom_val[15:8];
          fb1  = rom_val[7:0];
          fcnt = 2'd2;
        end else begin
          fb0  = rom_val[7:0];
          fcnt = 2'd1;
        end
      end
    end

    if (direct) begin
      bytes = dbytes;
      n     = dcnt;
    end else if (prefix) begin
      bytes = {fb1, fb0, g7u8_pkg::NBSP_TAIL, g7u8_pkg::NBSP_LEAD};
      n     = 3'd2 + {1'b0, fcnt};
    end else begin
      bytes = {16'h0000, fb1, fb0};
      n     = {1'b0, fcnt};
    end
  end

  assign q_push           = accept && (n != 3'd0);
  assign q_data.bytes     = bytes;
  assign q_data.last_idx  = g7u8_pkg::BIDX_W'(n - 3'd1);
  assign q_data.msg_end   = in_tlast || bad;
  assign q_data.bad       = bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r  <= 1'b0;
      drop_r <= 1'b0;
    end else if (accept) begin
      esc_r  <= esc_nxt;
      drop_r <= drop_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/g7u8_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// g7u8_queue
// Short register queue of byte bundles between front and back.
// ----------------------------------------------------------------------------
module g7u8_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire g7u8_pkg::bundle_t push_data,
  input  wire logic              pop,
  output g7u8_pkg::bundle_t      head,
  output logic                   empty,
  output logic                   full
);

  localparam logic [g7u8_pkg::QPTR_W-1:0] PTR_LAST = g7u8_pkg::QPTR_W'(g7u8_pkg::QUEUE_DEPTH - 1);
  localparam logic [g7u8_pkg::QCNT_W-1:0] CNT_FULL = g7u8_pkg::QCNT_W'(g7u8_pkg::QUEUE_DEPTH);

  g7u8_pkg::bundle_t               mem_r [g7u8_pkg::QUEUE_DEPTH];
  logic [g7u8_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [g7u8_pkg::QCNT_W-1:0]     cnt_r;
  logic                            do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CNT_FULL);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> src/g7u8_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// g7u8_back
// Holds one bundle and sends its bytes out one per cycle as out_tready allows,
// loading the next bundle from the queue as the last byte goes or when empty.
// ----------------------------------------------------------------------------
module g7u8_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire g7u8_pkg::bundle_t q_head,
  input  wire logic              q_empty,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [7:0]             out_tdata,  // [7:0] utf8_byte
  output logic                   out_tlast,  // msg_end
  output logic [1:0]             out_tuser   // [0] run_end, [1] bad_input
);

  g7u8_pkg::bundle_t               cur_r;
  logic                            cur_vld_r;
  logic [g7u8_pkg::BIDX_W-1:0]     idx_r;
  logic                            fire, at_last;

  assign fire       = cur_vld_r && out_tready;
  assign at_last    = (idx_r == cur_r.last_idx);
  assign q_pop      = !q_empty && (!cur_vld_r || (fire && at_last));

  assign out_tvalid = cur_vld_r;
  assign out_tdata  = cur_r.bytes[idx_r];
  assign out_tlast  = at_last && cur_r.msg_end;
  assign out_tuser  = {at_last && cur_r.bad, at_last};

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= '0;
    end else if (q_pop) begin
      cur_vld_r <= 1'b1;
      idx_r     <= '0;
    end else if (fire) begin
      if (at_last) cur_vld_r <= 1'b0;
      else         idx_r     <= idx_r + 1'b1;
    end
  end

`ifndef ASSERT_OFF
  // byte index never runs past the bundle length
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_vld_r |-> (idx_r <= cur_r.last_idx))
    else $error("byte index beyond bundle");

  // error result carries a zero byte and closes the message
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_vld_r && out_tuser[1]) |-> (out_tdata == g7u8_pkg::ERR_BYTE && out_tlast))
    else $error("error result malformed");

  // a stalled byte keeps its position in the bundle
  a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_vld_r && !out_tready) |=> (cur_vld_r && $stable(idx_r)))
    else $error("byte position moved under stall");
`endif

endmodule
`default_nettype wire
